>>> rtl/tbq_pkg.sv
// ----------------------------------------------------------------------------
// Touch button qualifier package
// Shared constants, codes, types and the touch decoder for the qualifier.
// ----------------------------------------------------------------------------
package tbq_pkg;

  // Number of press counters, one per button.
  localparam int unsigned NumButtons = 3;
  // The sensor word carries three buttons at most.
  localparam int unsigned NumDecode  = (NumButtons < 3) ? NumButtons : 3;
  localparam int unsigned ButtonIdxW = (NumButtons > 1) ? $clog2(NumButtons) : 1;

  localparam int unsigned TickW  = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgW   = 16;

  localparam logic [TickW-1:0]  TickMax  = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [TickW-1:0]  SamplePeriodRst  = TickW'(20);
  localparam logic [CountW-1:0] PressThresholdRst = CountW'(1);
  localparam logic [TickW-1:0]  ServoOffDelayRst = TickW'(1000);

  typedef enum logic [1:0] {
    CfgSamplePeriod   = 2'd0,
    CfgPressThreshold = 2'd1,
    CfgServoOffDelay  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OpTick     = 2'd0,
    OpSetServo = 2'd1,
    OpRead     = 2'd2
  } opcode_e;

  // Sample request from the top level to the press counter bank.
  typedef struct packed {
    logic       sample;
    logic [1:0] button;
  } press_req_t;

  // Qualification result for the current request.
  typedef struct packed {
    logic       hit;
    logic [1:0] button;
  } press_rsp_t;

  // Turns the touch flag and the one-hot sensor word into a button number,
  // zero when there is no touch or the word is not a valid one-hot code.
  function automatic logic [1:0] decode_touch(input logic flag, input logic [2:0] bits);
    logic [1:0] btn;
    btn = 2'd0;
    if (flag) begin
      for (int unsigned i = 0; i < NumDecode; i++) begin
        if (bits == 3'(1 << i)) begin
          btn = 2'(i + 1);
        end
      end
    end
    return btn;
  endfunction

endpackage

>>> rtl/tbq_press_bank.sv
// ----------------------------------------------------------------------------
// Press counter bank
// One saturating counter per button; reports when a touched button qualifies.
// ----------------------------------------------------------------------------
module tbq_press_bank import tbq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  press_req_t        req_i,
  input  logic [CountW-1:0] threshold_i,
  output press_rsp_t        rsp_o
);

  logic [CountW-1:0]     count_q [NumButtons];
  logic [CountW-1:0]     count_d [NumButtons];
  logic [1:0]            btn_m1;
  logic [ButtonIdxW-1:0] idx;
  logic [CountW-1:0]     count_inc;
  logic                  touched;

  assign touched   = (req_i.button != 2'd0);
  assign btn_m1    = req_i.button - 2'd1;
  assign idx       = ButtonIdxW'(btn_m1);
  assign count_inc = (count_q[idx] == CountMax) ? CountMax : count_q[idx] + CountW'(1);

  assign rsp_o.hit    = req_i.sample && touched && (count_inc > threshold_i);
  assign rsp_o.button = req_i.button;

  always_comb begin
    for (int unsigned i = 0; i < NumButtons; i++) begin
      count_d[i] = count_q[i];
      if (req_i.sample) begin
        if (touched) begin
          if (ButtonIdxW'(i) == idx) begin
            count_d[i] = rsp_o.hit ? '0 : count_inc;
          end
        end else if (count_q[i] != '0) begin
          count_d[i] = count_q[i] - CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NumButtons; i++) begin
        count_q[i] <= '0;
      end
    end else if (en_i) begin
      for (int unsigned i = 0; i < NumButtons; i++) begin
        count_q[i] <= count_d[i];
      end
    end
  end

endmodule

>>> rtl/touch_button_qualifier_servo_lockout.sv
// ----------------------------------------------------------------------------
// Touch button qualifier with servo lockout
// Qualifies three touch buttons by sampling and counting, with a servo lockout.
// ----------------------------------------------------------------------------
// Each input beat is one event: a tick, a new servo moving mask, or a read of
// the latched button. A beat is first captured in an input register;
// it is then evaluated against the block state and its result is
// written into the output register. One beat can be taken every
// cycle while the output is not stalled. The limit is the single pass
// through the state update logic, which must finish before the next
// beat can see the updated counters. A new beat is taken while a finished
// result still waits; the input stalls only when both the input and
// output registers are full and the output is stalled. Ticks advance two
// saturating 16-bit counters; once the sample counter exceeds the sample
// period a sample is taken. Without servo flags, a one-hot touch bumps that
// button's press counter and latches the button when the count exceeds the
// threshold; with flags set, touches are ignored and the first flagged servo
// is watched until it has been still for longer than the off delay.
// Configuration registers may only be written while the block is idle.
module touch_button_qualifier_servo_lockout import tbq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Configuration write port
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  // Input channel
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      opcode_i,
  input  logic [1:0]      servo_mask_i,
  input  logic            touch_flag_i,
  input  logic [2:0]      sensor_bits_i,
  input  logic            servo_one_moving_i,
  input  logic            servo_two_moving_i,
  // Output channel
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      button_out_o,
  output logic [1:0]      servo_flags_out_o,
  output logic            sample_taken_o
);

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] servo_mask;
    logic       touch_flag;
    logic [2:0] sensor_bits;
    logic       servo_one_moving;
    logic       servo_two_moving;
  } in_beat_t;

  // Configuration registers.
  logic [TickW-1:0]  sample_period_q;
  logic [CountW-1:0] press_threshold_q;
  logic [TickW-1:0]  servo_off_delay_q;

  // Input register.
  logic     in_valid_q;
  in_beat_t in_beat_q;
  logic     in_accept;
  logic     advance;

  // Block state.
  logic [TickW-1:0] ticks_sample_q, ticks_sample_d;
  logic [TickW-1:0] ticks_servo_q, ticks_servo_d;
  logic [1:0]       latched_q, latched_d;
  logic [1:0]       servo_flags_q, servo_flags_d;

  // Output register.
  logic       out_valid_q;
  logic [1:0] button_q, button_d;
  logic       sample_q, sample_d;

  // Evaluation signals.
  logic [TickW-1:0] ticks_sample_inc;
  logic [TickW-1:0] ticks_servo_inc;
  logic             do_sample;
  logic             moving;
  press_req_t       press_req;
  press_rsp_t       press_rsp;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_period_q   <= SamplePeriodRst;
      press_threshold_q <= PressThresholdRst;
      servo_off_delay_q <= ServoOffDelayRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgSamplePeriod:   sample_period_q   <= cfg_wdata_i;
        CfgPressThreshold: press_threshold_q <= cfg_wdata_i[CountW-1:0];
        CfgServoOffDelay:  servo_off_delay_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the evaluation stage moves whenever the output register is
  // empty or being drained this cycle.
  // --------------------------------------------------------------------------
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_beat_q <= '{opcode:           opcode_i,
                     servo_mask:       servo_mask_i,
                     touch_flag:       touch_flag_i,
                     sensor_bits:      sensor_bits_i,
                     servo_one_moving: servo_one_moving_i,
                     servo_two_moving: servo_two_moving_i};
    end
  end

  // --------------------------------------------------------------------------
  // Evaluation of the registered beat
  // --------------------------------------------------------------------------
  assign ticks_sample_inc = (ticks_sample_q == TickMax) ? TickMax
                                                        : ticks_sample_q + TickW'(1);
  assign ticks_servo_inc  = (ticks_servo_q == TickMax) ? TickMax
                                                       : ticks_servo_q + TickW'(1);

  // The lockout watches servo one if its flag is set, otherwise servo two.
  assign moving = servo_flags_q[0] ? in_beat_q.servo_one_moving
                                   : in_beat_q.servo_two_moving;

  assign do_sample = (opcode_e'(in_beat_q.opcode) == OpTick)
                     && (ticks_sample_inc > sample_period_q);

  // Touches are only decoded while no servo is flagged.
  assign press_req.sample = do_sample;
  assign press_req.button = (servo_flags_q == 2'd0)
                            ? decode_touch(in_beat_q.touch_flag, in_beat_q.sensor_bits)
                            : 2'd0;

  tbq_press_bank u_press_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (in_valid_q && advance),
    .req_i       (press_req),
    .threshold_i (press_threshold_q),
    .rsp_o       (press_rsp)
  );

  always_comb begin
    ticks_sample_d = ticks_sample_q;
    ticks_servo_d  = ticks_servo_q;
    latched_d      = latched_q;
    servo_flags_d  = servo_flags_q;
    button_d       = 2'd0;
    sample_d       = 1'b0;
    unique case (opcode_e'(in_beat_q.opcode))
      OpTick: begin
        ticks_sample_d = ticks_sample_inc;
        ticks_servo_d  = ticks_servo_inc;
        if (do_sample) begin
          ticks_sample_d = '0;
          sample_d       = 1'b1;
          if (servo_flags_q != 2'd0) begin
            if (moving) begin
              ticks_servo_d = '0;
            end else if (ticks_servo_inc > servo_off_delay_q) begin
              servo_flags_d = 2'd0;
            end
          end
          if (press_rsp.hit) begin
            latched_d = press_rsp.button;
          end
          button_d = press_rsp.hit ? press_rsp.button : latched_q;
        end
      end
      OpSetServo: begin
        servo_flags_d = in_beat_q.servo_mask;
      end
      OpRead: begin
        button_d  = latched_q;
        latched_d = 2'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_sample_q <= '0;
      ticks_servo_q  <= '0;
      latched_q      <= 2'd0;
      servo_flags_q  <= 2'd0;
    end else if (in_valid_q && advance) begin
      ticks_sample_q <= ticks_sample_d;
      ticks_servo_q  <= ticks_servo_d;
      latched_q      <= latched_d;
      servo_flags_q  <= servo_flags_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) begin
      button_q <= button_d;
      sample_q <= sample_d;
    end
  end

  // The flags register is only written by an evaluated beat, so it already
  // holds the value after the beat in the output register.
  logic [1:0] flags_out_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) begin
      flags_out_q <= servo_flags_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign button_out_o      = button_q;
  assign servo_flags_out_o = flags_out_q;
  assign sample_taken_o    = sample_q;

endmodule

>>> rtl/tbq_checker.sv
// ----------------------------------------------------------------------------
// Touch button qualifier checker
// Port-level assertions on the qualifier, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tbq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] button_out_o,
  input logic [1:0] servo_flags_out_o,
  input logic       sample_taken_o
);

  // A stalled result beat is held unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(button_out_o)
      && $stable(servo_flags_out_o) && $stable(sample_taken_o))
    else $error("stalled result beat changed");

  // The input side only backs up when a result is waiting and stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // A result that becomes valid comes from an input beat that was accepted earlier.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without an accepted input beat");

endmodule

bind touch_button_qualifier_servo_lockout tbq_checker u_tbq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .button_out_o      (button_out_o),
  .servo_flags_out_o (servo_flags_out_o),
  .sample_taken_o    (sample_taken_o)
);

>>> tb/tb_touch_button_qualifier_servo_lockout.sv
// ----------------------------------------------------------------------------
// Touch button qualifier with servo lockout: self-checking testbench
// Sends tick, servo and read beats through the valid/stall input channel and
// checks every result beat against a cycle-free behavioural prediction. It
// steps through several register settings, including the highest press
// threshold at which a button can still latch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_touch_button_qualifier_servo_lockout;
  import tbq_pkg::*;

  // Opcode 3 has no meaning in the block, so it is only named here.
  localparam logic [1:0] OpUnused = 2'd3;

  // 12 ns clock period.
  localparam int unsigned HalfPeriod = 6;
  // Hard stop: far beyond the slowest legal run.
  localparam longint unsigned RunLimitNs = 64'd2_400_000;

  // One input beat, with the fields exactly as the ports carry them.
  typedef struct packed {
    logic [1:0] op;
    logic [1:0] servo_mask;
    logic       touch;
    logic [2:0] sensor;
    logic       servo_one;
    logic       servo_two;
  } beat_t;

  // One result beat.
  typedef struct packed {
    logic [1:0] button;
    logic [1:0] servo_flags;
    logic       sampled;
  } result_t;

  logic            clk_i              = 1'b0;
  logic            rst_ni             = 1'b0;
  logic            cfg_we_i           = 1'b0;
  logic [1:0]      cfg_idx_i          = '0;
  logic [CfgW-1:0] cfg_wdata_i        = '0;
  logic            in_valid_i         = 1'b0;
  logic            in_stall_o;
  logic [1:0]      opcode_i           = '0;
  logic [1:0]      servo_mask_i       = '0;
  logic            touch_flag_i       = 1'b0;
  logic [2:0]      sensor_bits_i      = '0;
  logic            servo_one_moving_i = 1'b0;
  logic            servo_two_moving_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i        = 1'b0;
  logic [1:0]      button_out_o;
  logic [1:0]      servo_flags_out_o;
  logic            sample_taken_o;

  touch_button_qualifier_servo_lockout i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .servo_mask_i       (servo_mask_i),
    .touch_flag_i       (touch_flag_i),
    .sensor_bits_i      (sensor_bits_i),
    .servo_one_moving_i (servo_one_moving_i),
    .servo_two_moving_i (servo_two_moving_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .button_out_o       (button_out_o),
    .servo_flags_out_o  (servo_flags_out_o),
    .sample_taken_o     (sample_taken_o)
  );

  // Beats waiting to be sent, and results predicted but not yet seen.
  beat_t   pending_beats[$];
  result_t expected_results[$];

  int unsigned fault_count = 0;
  // Set by the monitor when the input beat on the port was taken at the last
  // rising edge; the driver reads it at the following falling edge.
  bit          beat_taken  = 1'b0;
  // When set, neither side idles; gives stretches of back-to-back traffic.
  bit          steady      = 1'b0;

  // Press bursts: the random stimulus mostly touches one button for a run
  // of samples, which is what it takes to get a button latched at all.
  int unsigned burst_button = 0;
  int unsigned burst_left   = 0;

  // --------------------------------------------------------------------------
  // Predicted state of the qualifier, plus its own copy of the registers.
  // Reset is applied once only, so the reset values stand as initialisers.
  // --------------------------------------------------------------------------
  logic [TickW-1:0]  period_reg        = SamplePeriodRst;
  logic [CountW-1:0] threshold_reg     = PressThresholdRst;
  logic [TickW-1:0]  off_delay_reg     = ServoOffDelayRst;
  logic [TickW-1:0]  tick_count        = '0;
  logic [TickW-1:0]  servo_quiet_ticks = '0;
  logic [CountW-1:0] press_count [NumButtons];
  logic [1:0]        held_button       = '0;
  logic [1:0]        servo_lock        = '0;

  initial begin
    for (int i = 0; i < NumButtons; i++) begin
      press_count[i] = '0;
    end
  end

  // Button number named by a touch, zero when the sensor word is not one-hot
  // or names a button that does not exist.
  function automatic logic [1:0] touched_button(input logic flag, input logic [2:0] word);
    logic [1:0] btn;
    btn = 2'd0;
    if (flag) begin
      case (word)
        3'b001:  btn = 2'd1;
        3'b010:  btn = (NumButtons > 1) ? 2'd2 : 2'd0;
        3'b100:  btn = (NumButtons > 2) ? 2'd3 : 2'd0;
        default: btn = 2'd0;
      endcase
    end
    return btn;
  endfunction

  // Advances the predicted state by one accepted beat and returns the
  // result beat that the block has to produce for it.
  function automatic result_t predict_result(input beat_t b);
    result_t    res;
    logic [1:0] btn;
    logic       moving;
    int         idx;
    res = '0;
    case (b.op)
      OpTick: begin
        // Both tick counters saturate and advance before the compare.
        if (tick_count != TickMax) tick_count = tick_count + 1'b1;
        if (servo_quiet_ticks != TickMax) servo_quiet_ticks = servo_quiet_ticks + 1'b1;
        if (tick_count > period_reg) begin
          btn = 2'd0;
          if (servo_lock != 2'b00) begin
            // Only the first flagged servo is watched; touches are ignored.
            moving = servo_lock[0] ? b.servo_one : b.servo_two;
            if (moving) begin
              servo_quiet_ticks = '0;
            end else if (servo_quiet_ticks > off_delay_reg) begin
              servo_lock = 2'b00;
            end
          end else begin
            btn = touched_button(b.touch, b.sensor);
          end
          if (btn != 2'd0) begin
            idx = int'(btn) - 1;
            if (press_count[idx] != CountMax) press_count[idx] = press_count[idx] + 1'b1;
            if (press_count[idx] > threshold_reg) begin
              held_button      = btn;
              press_count[idx] = '0;
            end
          end else begin
            // A sample without a valid touch lets every counter decay.
            for (int i = 0; i < NumButtons; i++) begin
              if (press_count[i] != '0) press_count[i] = press_count[i] - 1'b1;
            end
          end
          tick_count  = '0;
          res.button  = held_button;
          res.sampled = 1'b1;
        end
      end
      OpSetServo: begin
        // The off timer keeps running; only the flags change.
        servo_lock = b.servo_mask;
      end
      OpRead: begin
        res.button  = held_button;
        held_button = 2'd0;
      end
      default: begin
      end
    endcase
    res.servo_flags = servo_lock;
    return res;
  endfunction

  function automatic void note_fault(input string msg);
    if (fault_count < 10) $display("[%0t] mismatch: %s", $realtime, msg);
    fault_count++;
  endfunction

  // --------------------------------------------------------------------------
  // Beat builders and the random beat source.
  // --------------------------------------------------------------------------
  function automatic beat_t tick_beat(input logic touch, input logic [2:0] sensor,
                                      input logic s1, input logic s2);
    beat_t b;
    b            = '0;
    b.op         = OpTick;
    b.touch      = touch;
    b.sensor     = sensor;
    b.servo_one  = s1;
    b.servo_two  = s2;
    return b;
  endfunction

  function automatic beat_t op_beat(input logic [1:0] op, input logic [1:0] mask);
    beat_t b;
    b            = '0;
    b.op         = op;
    b.servo_mask = mask;
    return b;
  endfunction

  // Mostly ticks, and most of those carry a clean one-hot touch on the
  // current burst button; the rest is reads, servo updates and noise.
  function automatic beat_t random_beat();
    beat_t       b;
    int unsigned pick;
    b.servo_mask = 2'($urandom_range(3));
    b.touch      = 1'($urandom_range(1));
    b.sensor     = 3'($urandom_range(7));
    b.servo_one  = ($urandom_range(99) < 15);
    b.servo_two  = ($urandom_range(99) < 15);
    pick         = $urandom_range(99);
    if (pick < 70) begin
      b.op = OpTick;
      if (pick < 45) begin
        if (burst_left == 0) begin
          burst_button = $urandom_range(NumButtons - 1);
          burst_left   = $urandom_range(1, 6);
        end
        burst_left--;
        b.touch  = 1'b1;
        b.sensor = 3'(1 << burst_button);
      end
    end else if (pick < 80) begin
      b.op = OpSetServo;
      // Clearing the flags now and then keeps the lockout from dominating.
      if ($urandom_range(99) < 40) b.servo_mask = 2'b00;
    end else if (pick < 96) begin
      b.op = OpRead;
    end else begin
      b.op = OpUnused;
    end
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, driver, receiver and monitor.
  // --------------------------------------------------------------------------
  initial begin
    forever #(HalfPeriod) clk_i = ~clk_i;
  end

  // The driver moves to the next beat only once the current one has been
  // taken, so a stalled beat holds still. Valid is assigned once per edge.
  always @(negedge clk_i) begin
    beat_t b;
    if (rst_ni && (!in_valid_i || beat_taken)) begin
      if (pending_beats.size() > 0 && (steady || $urandom_range(99) >= 16)) begin
        b                  = pending_beats.pop_front();
        opcode_i           <= b.op;
        servo_mask_i       <= b.servo_mask;
        touch_flag_i       <= b.touch;
        sensor_bits_i      <= b.sensor;
        servo_one_moving_i <= b.servo_one;
        servo_two_moving_i <= b.servo_two;
        in_valid_i         <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // The receiving side stalls at random, except in steady stretches.
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 16);
  end

  // At each rising edge: check a result beat if one is taken, predict the
  // input beat if one is taken, and mirror any register write.
  always @(posedge clk_i) begin
    beat_t   seen;
    result_t want;
    beat_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          note_fault($sformatf("result with nothing expected: button %0d flags %0d sample %0d",
                               button_out_o, servo_flags_out_o, sample_taken_o));
        end else begin
          want = expected_results.pop_front();
          if (button_out_o !== want.button)
            note_fault($sformatf("button_out expected %0d, got %0d", want.button, button_out_o));
          if (servo_flags_out_o !== want.servo_flags)
            note_fault($sformatf("servo_flags_out expected %0d, got %0d",
                                 want.servo_flags, servo_flags_out_o));
          if (sample_taken_o !== want.sampled)
            note_fault($sformatf("sample_taken expected %0d, got %0d",
                                 want.sampled, sample_taken_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        beat_taken = 1'b1;
        seen.op         = opcode_i;
        seen.servo_mask = servo_mask_i;
        seen.touch      = touch_flag_i;
        seen.sensor     = sensor_bits_i;
        seen.servo_one  = servo_one_moving_i;
        seen.servo_two  = servo_two_moving_i;
        expected_results.push_back(predict_result(seen));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSamplePeriod:   period_reg    = cfg_wdata_i;
          CfgPressThreshold: threshold_reg = cfg_wdata_i[CountW-1:0];
          CfgServoOffDelay:  off_delay_reg = cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing helpers.
  // --------------------------------------------------------------------------
  // Waits until every beat has been sent and every result has come back,
  // then lets the pipeline run dry before anything else happens.
  task automatic settle_idle();
    while (pending_beats.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One register setting followed by a stretch of random beats.
  task automatic run_phase(input logic [TickW-1:0] period, input logic [CountW-1:0] thresh,
                           input logic [TickW-1:0] off_delay, input int unsigned beats,
                           input bit no_idle);
    write_reg(CfgSamplePeriod, period);
    write_reg(CfgPressThreshold, CfgW'(thresh));
    write_reg(CfgServoOffDelay, off_delay);
    steady = no_idle;
    for (int i = 0; i < beats; i++) begin
      pending_beats.push_back(random_beat());
    end
    settle_idle();
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: a sample on every tick, a low threshold and a short
    // off delay, so that each case shows up within a few beats.
    write_reg(CfgSamplePeriod, 16'd0);
    write_reg(CfgPressThreshold, 16'd1);
    write_reg(CfgServoOffDelay, 16'd2);
    pending_beats.push_back(op_beat(OpRead, 2'b00));          // nothing latched yet
    pending_beats.push_back(op_beat(OpUnused, 2'b11));        // unused opcode
    pending_beats.push_back(tick_beat(1'b1, 3'b001, 1'b1, 1'b1));
    pending_beats.push_back(tick_beat(1'b1, 3'b001, 1'b0, 1'b0)); // button one latches
    pending_beats.push_back(op_beat(OpRead, 2'b00));
    pending_beats.push_back(op_beat(OpRead, 2'b00));          // read has cleared it
    pending_beats.push_back(tick_beat(1'b1, 3'b011, 1'b0, 1'b0)); // not one-hot
    pending_beats.push_back(tick_beat(1'b1, 3'b111, 1'b0, 1'b0));
    pending_beats.push_back(tick_beat(1'b1, 3'b000, 1'b0, 1'b0));
    pending_beats.push_back(tick_beat(1'b0, 3'b100, 1'b0, 1'b0)); // word without flag
    pending_beats.push_back(tick_beat(1'b1, 3'b100, 1'b0, 1'b0));
    pending_beats.push_back(tick_beat(1'b1, 3'b100, 1'b0, 1'b0)); // button three latches
    pending_beats.push_back(tick_beat(1'b1, 3'b010, 1'b0, 1'b0));
    pending_beats.push_back(tick_beat(1'b0, 3'b000, 1'b0, 1'b0)); // counter decays
    // Servo one flagged: touches are ignored and only servo one is watched.
    pending_beats.push_back(op_beat(OpSetServo, 2'b01));
    pending_beats.push_back(tick_beat(1'b1, 3'b001, 1'b1, 1'b0));
    pending_beats.push_back(tick_beat(1'b1, 3'b001, 1'b0, 1'b1));
    pending_beats.push_back(tick_beat(1'b0, 3'b000, 1'b0, 1'b0));
    pending_beats.push_back(tick_beat(1'b0, 3'b000, 1'b0, 1'b0)); // flags time out
    // Servo two alone flagged: servo one movement must not count.
    pending_beats.push_back(op_beat(OpSetServo, 2'b10));
    pending_beats.push_back(tick_beat(1'b0, 3'b000, 1'b0, 1'b1));
    pending_beats.push_back(tick_beat(1'b0, 3'b000, 1'b1, 1'b0));
    pending_beats.push_back(tick_beat(1'b0, 3'b000, 1'b1, 1'b0));
    pending_beats.push_back(tick_beat(1'b0, 3'b000, 1'b1, 1'b0));
    // Both flagged: servo one takes precedence.
    pending_beats.push_back(op_beat(OpSetServo, 2'b11));
    pending_beats.push_back(tick_beat(1'b1, 3'b010, 1'b0, 1'b1));
    pending_beats.push_back(op_beat(OpSetServo, 2'b00));
    pending_beats.push_back(op_beat(OpRead, 2'b00));
    settle_idle();

    // Random part over a spread of settings.
    run_phase(16'd1, 8'd1, 16'd2, 140, 1'b0);
    run_phase(16'd0, 8'd0, 16'd0, 140, 1'b0);
    run_phase(16'd2, 8'd3, 16'd10, 140, 1'b0);
    // Highest threshold that can still latch: one long press on button two has
    // to reach a count of 255 before it latches.
    write_reg(CfgPressThreshold, 16'd254);
    write_reg(CfgSamplePeriod, 16'd0);
    pending_beats.push_back(op_beat(OpSetServo, 2'b00));
    for (int i = 0; i < 260; i++) begin
      pending_beats.push_back(tick_beat(1'b1, 3'b010, 1'b0, 1'b0));
    end
    pending_beats.push_back(op_beat(OpRead, 2'b00));
    settle_idle();
    run_phase(16'd0, 8'd254, 16'd1, 140, 1'b0);
    // Back to the reset values; samples are rare here.
    run_phase(SamplePeriodRst, PressThresholdRst, ServoOffDelayRst, 140, 1'b0);
    // A stretch without any idling on either side.
    run_phase(16'd0, 8'd2, 16'd4, 140, 1'b1);

    repeat (8) @(posedge clk_i);
    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #(RunLimitNs);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> touch_button_qualifier_servo_lockout.f
rtl/tbq_pkg.sv
rtl/tbq_press_bank.sv
rtl/touch_button_qualifier_servo_lockout.sv
rtl/tbq_checker.sv
tb/tb_touch_button_qualifier_servo_lockout.sv
